// File: hdl/aes128_pkg.sv
// package: aes-128 types, constants and round functions
package aes128_pkg;

  localparam int unsigned BLK_W = 128;
  localparam int unsigned HALF_W = 64;
  localparam int unsigned FULL_ROUNDS = 9;
  localparam int unsigned NUM_STAGES = FULL_ROUNDS + 1;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 8'd1;

  typedef logic [BLK_W-1:0] blk_t;
  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic valid;
    logic last;
  } stg_ctl_t;

  localparam byte_t SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam byte_t RCON [NUM_STAGES] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // byte n of the state lives at bits [127-8n -: 8]
  function automatic byte_t get_byte(input blk_t b, input int unsigned n);
    get_byte = b[BLK_W-1-8*n -: 8];
  endfunction

  function automatic byte_t xtime(input byte_t x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // one round of the key schedule
  function automatic blk_t key_step(input blk_t k, input byte_t rc);
    byte_t t [4];
    byte_t o [16];
    blk_t  r;
    t[0] = SBOX[get_byte(k, 13)] ^ rc;
    t[1] = SBOX[get_byte(k, 14)];
    t[2] = SBOX[get_byte(k, 15)];
    t[3] = SBOX[get_byte(k, 12)];
    for (int i = 0; i < 4; i++) o[i] = get_byte(k, i) ^ t[i];
    for (int i = 4; i < 16; i++) o[i] = get_byte(k, i) ^ o[i-4];
    for (int i = 0; i < 16; i++) r[BLK_W-1-8*i -: 8] = o[i];
    key_step = r;
  endfunction

  // subbytes, shiftrows and optional mixcolumns
  function automatic blk_t round_fn(input blk_t s, input logic do_mix);
    byte_t t [16];
    byte_t a0, a1, a2, a3, al;
    blk_t  r;
    for (int c = 0; c < 4; c++)
      for (int w = 0; w < 4; w++)
        t[4*c+w] = SBOX[get_byte(s, 4*((c+w)%4)+w)];
    if (do_mix) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        al = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) r[BLK_W-1-8*i -: 8] = t[i];
    round_fn = r;
  endfunction

endpackage

// File: hdl/aes128_if.sv
// interfaces: block stream channel and configuration write channel
interface aes128_blk_if;
  logic                             valid;
  logic                             ready;
  logic [aes128_pkg::HALF_W-1:0]    data_high;
  logic [aes128_pkg::HALF_W-1:0]    data_low;
  modport source (output valid, data_high, data_low, input ready);
  modport sink (input valid, data_high, data_low, output ready);
endinterface

interface aes128_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [aes128_pkg::CFG_IDX_W-1:0] index;
  logic [aes128_pkg::HALF_W-1:0]    wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

// File: hdl/aes128_round.sv
// one pipelined cipher round: state and round key move one stage
module aes128_round (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic [7:0]            rcon,
  input  aes128_pkg::stg_ctl_t  ctl_in,
  input  aes128_pkg::blk_t      state_in,
  input  aes128_pkg::blk_t      key_in,
  output aes128_pkg::stg_ctl_t  ctl_out,
  output aes128_pkg::blk_t      state_out,
  output aes128_pkg::blk_t      key_out
);
  aes128_pkg::stg_ctl_t ctl_r;
  aes128_pkg::blk_t     state_r, key_r, key_nxt, state_nxt;

  always_comb begin
    key_nxt   = aes128_pkg::key_step(key_in, rcon);
    state_nxt = aes128_pkg::round_fn(state_in, !ctl_in.last) ^ key_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      state_r <= state_nxt;
      key_r   <= key_nxt;
    end
  end

  assign ctl_out   = ctl_r;
  assign state_out = state_r;
  assign key_out   = key_r;
endmodule

// File: hdl/block_cipher_encrypt_128.sv
// top level: fully unrolled aes-128 encryption pipeline
// Encrypts one 128-bit block per item with AES-128 under the key in registers
// key_high (index 0) and key_low (index 1); other indexes are ignored. The user
// must write the key only while idle; the block does not enforce this. The key
// is sampled with the item on entry. Eleven register stages (initial key addition,
// nine full rounds, final round), each round stage computing its round key
// alongside, so a new item is taken every cycle while the output is not stalled. A
// stage advances when the one after it does or when it is empty; a stalled output
// holds full stages while the front fills empty ones, squeezing out bubbles.
module block_cipher_encrypt_128 (
  input logic clk,
  input logic rst_n,
  aes128_blk_if.sink   in_blk,
  aes128_blk_if.source out_blk,
  aes128_cfg_if.sink   cfg_wr
);
  localparam int unsigned NS = aes128_pkg::NUM_STAGES;

  logic [63:0] key_high_r, key_low_r;

  aes128_pkg::stg_ctl_t ctl   [NS+1];
  aes128_pkg::blk_t     state [NS+1];
  aes128_pkg::blk_t     key   [NS+1];
  logic                 adv   [NS+1];

  aes128_pkg::stg_ctl_t ctl0_r;
  aes128_pkg::blk_t     state0_r, key0_r;

  // config writes always accepted
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        aes128_pkg::REG_KEY_HIGH: key_high_r <= cfg_wr.wdata;
        aes128_pkg::REG_KEY_LOW:  key_low_r  <= cfg_wr.wdata;
        default: ;
      endcase
    end
  end

  // stage k advances when downstream advances or stage k is empty
  assign adv[NS] = out_blk.ready || !ctl[NS].valid;
  for (genvar k = NS; k > 0; k--) begin : g_adv
    assign adv[k-1] = adv[k] || !ctl[k-1].valid;
  end

  assign in_blk.ready = adv[0];

  // stage 0: initial key addition
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r <= '0;
    end else if (adv[0]) begin
      ctl0_r <= '{valid: in_blk.valid, last: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      state0_r <= {in_blk.data_high, in_blk.data_low} ^ {key_high_r, key_low_r};
      key0_r   <= {key_high_r, key_low_r};
    end
  end

  assign ctl[0]   = ctl0_r;
  assign state[0] = state0_r;
  assign key[0]   = key0_r;

  for (genvar r = 0; r < NS; r++) begin : g_rnd
    aes128_pkg::stg_ctl_t ci;
    // last flag marks the final round, which skips mixcolumns
    assign ci = '{valid: ctl[r].valid, last: (r == NS - 1)};
    aes128_round u_round (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv[r+1]),
      .rcon     (aes128_pkg::RCON[r]),
      .ctl_in   (ci),
      .state_in (state[r]),
      .key_in   (key[r]),
      .ctl_out  (ctl[r+1]),
      .state_out(state[r+1]),
      .key_out  (key[r+1])
    );
  end

  assign out_blk.valid     = ctl[NS].valid;
  assign out_blk.data_high = state[NS][127:64];
  assign out_blk.data_low  = state[NS][63:0];
endmodule

// File: hdl/aes128_checker.sv
// checker: port-level properties of the cipher pipeline
module aes128_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_high,
  input logic [63:0] out_low,
  input logic        cfg_ready
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_high) && $stable(out_low))
    else $error("result changed while stalled");

  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output free");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config port not ready");

  a_no_out_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result right after reset");
endmodule

bind block_cipher_encrypt_128 aes128_checker u_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_blk.ready),
  .out_valid(out_blk.valid),
  .out_ready(out_blk.ready),
  .out_high (out_blk.data_high),
  .out_low  (out_blk.data_low),
  .cfg_ready(cfg_wr.ready)
);
